FILE: rtl/core/array_margin_sum_defines.svh
// array_margin_sum_defines.svh: assertion macros shared by the margin sum rtl
// depends on: nothing; users must have clk and rst_n in scope
`ifndef ARRAY_MARGIN_SUM_DEFINES_SVH
`define ARRAY_MARGIN_SUM_DEFINES_SVH

// plain invariant, checked at every edge out of reset
`define AMS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define AMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ams_pkg.sv
// ams_pkg: constants, register codes and shared types of the margin sum block
// depends on: nothing
`timescale 1ns / 1ps

package ams_pkg;

  localparam int MAX_DIMS     = 4;
  localparam int MAX_EXTENT   = 256;
  localparam int RESULT_DEPTH = 1024;
  localparam int MAX_KEPT     = MAX_DIMS - 1;

  localparam int DIM_W   = 3;
  localparam int KEPT_W  = 2;
  localparam int ORDER_W = 8;
  localparam int SLOT_W  = 2;
  localparam int COORD_W = $clog2(MAX_EXTENT);
  localparam int EXT_W   = COORD_W + 1;
  localparam int IDX_W   = $clog2(RESULT_DEPTH);
  localparam int LEN_W   = IDX_W + 1;
  localparam int VALUE_W = 32;
  localparam int SUM_W   = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic KIND_ELEM  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_COUNT,
    REG_EXTENT_0,
    REG_EXTENT_1,
    REG_EXTENT_2,
    REG_EXTENT_3,
    REG_KEPT_COUNT,
    REG_KEPT_ORDER
  } cfg_reg_t;

  typedef struct packed {
    logic                              busy;
    logic                              err;
    logic [IDX_W-1:0]                  clr_addr;
    logic [LEN_W-1:0]                  len;
    logic [DIM_W-1:0]                  dim_count;
    logic [MAX_DIMS-1:0][EXT_W-1:0]    extent;
    logic [MAX_DIMS-1:0][IDX_W-1:0]    stride;
  } cfg_info_t;

  typedef struct packed {
    logic                      drain;
    logic                      err;
    logic                      last;
    logic [IDX_W-1:0]          addr;
    logic [VALUE_W-1:0]        value;
  } q_item_t;

  typedef struct packed {
    logic              sat;
    logic [SUM_W-1:0]  sum;
  } acc_word_t;

endpackage

FILE: rtl/core/ams_ifs.sv
// ams_ifs: valid/ready channel interfaces for input words and result words
// depends on: ams_pkg
`timescale 1ns / 1ps

interface ams_in_if import ams_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ams_out_if import ams_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SUM_W-1:0]    sum;
  logic [IDX_W-1:0]           out_index;
  logic                       last;
  logic                       saturated;
  logic                       config_error;

  modport source (output valid, output sum, output out_index, output last,
                  output saturated, output config_error, input ready);
  modport sink   (input valid, input sum, input out_index, input last,
                  input saturated, input config_error, output ready);
endinterface

FILE: rtl/core/ams_cfg.sv
// ams_cfg: configuration registers, validity check, stride setup and clearing pass
// depends on: ams_pkg
`timescale 1ns / 1ps

module ams_cfg import ams_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_info_t              info
);

  logic [DIM_W-1:0]    dim_count_r;
  logic [EXT_W-1:0]    extent_r [MAX_DIMS];
  logic [KEPT_W-1:0]   kept_count_r;
  logic [ORDER_W-1:0]  kept_order_r;

  logic                busy_r;
  logic [IDX_W-1:0]    clr_addr_r;
  logic [LEN_W-1:0]    len_r;
  logic                ovf_r;
  logic [IDX_W-1:0]    stride_r [MAX_DIMS];

  logic                      cfg_hit;
  logic [SLOT_W-1:0]         slot_m [MAX_KEPT];
  logic [SLOT_W-1:0]         step_j;
  logic [SLOT_W-1:0]         step_m;
  logic                      setup_step;
  logic [LEN_W+EXT_W-1:0]    prod;
  logic                      static_err;

  assign cfg_hit = cfg_we && (cfg_idx <= REG_KEPT_ORDER);

  always_comb begin
    for (int j = 0; j < MAX_KEPT; j++) begin
      slot_m[j] = kept_order_r[j*SLOT_W +: SLOT_W];
    end
  end

  // one kept margin per cycle at the start of the clearing pass
  assign step_j     = clr_addr_r[SLOT_W-1:0];
  assign step_m     = kept_order_r[{step_j, 1'b0} +: SLOT_W];
  assign setup_step = (clr_addr_r < IDX_W'(MAX_KEPT)) && (step_j < kept_count_r);
  assign prod       = (LEN_W+EXT_W)'(len_r) * (LEN_W+EXT_W)'(extent_r[step_m]);

  always_comb begin
    static_err = 1'b0;
    if (dim_count_r < DIM_W'(2) || dim_count_r > DIM_W'(MAX_DIMS)) begin
      static_err = 1'b1;
    end
    for (int j = 0; j < MAX_DIMS; j++) begin
      if (DIM_W'(j) < dim_count_r &&
          (extent_r[j] == '0 || extent_r[j] > EXT_W'(MAX_EXTENT))) begin
        static_err = 1'b1;
      end
    end
    if (kept_count_r == '0 || DIM_W'(kept_count_r) >= dim_count_r) begin
      static_err = 1'b1;
    end
    for (int j = 0; j < MAX_KEPT; j++) begin
      if (KEPT_W'(j) < kept_count_r) begin
        if (DIM_W'(slot_m[j]) >= dim_count_r) begin
          static_err = 1'b1;
        end
        for (int k = 0; k < j; k++) begin
          if (slot_m[k] == slot_m[j]) begin
            static_err = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r  <= DIM_W'(2);
      kept_count_r <= KEPT_W'(1);
      kept_order_r <= '0;
      for (int j = 0; j < MAX_DIMS; j++) begin
        extent_r[j] <= EXT_W'(1);
        stride_r[j] <= '0;
      end
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
      len_r      <= LEN_W'(1);
      ovf_r      <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_idx)
        REG_DIM_COUNT:  dim_count_r  <= cfg_data[DIM_W-1:0];
        REG_EXTENT_0:   extent_r[0]  <= cfg_data[EXT_W-1:0];
        REG_EXTENT_1:   extent_r[1]  <= cfg_data[EXT_W-1:0];
        REG_EXTENT_2:   extent_r[2]  <= cfg_data[EXT_W-1:0];
        REG_EXTENT_3:   extent_r[3]  <= cfg_data[EXT_W-1:0];
        REG_KEPT_COUNT: kept_count_r <= cfg_data[KEPT_W-1:0];
        REG_KEPT_ORDER: kept_order_r <= cfg_data[ORDER_W-1:0];
        default:        ;
      endcase
      for (int j = 0; j < MAX_DIMS; j++) begin
        stride_r[j] <= '0;
      end
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
      len_r      <= LEN_W'(1);
      ovf_r      <= 1'b0;
    end else if (busy_r) begin
      if (setup_step) begin
        stride_r[step_m] <= len_r[IDX_W-1:0];
        len_r            <= prod[LEN_W-1:0];
        if (prod > (LEN_W+EXT_W)'(RESULT_DEPTH)) begin
          ovf_r <= 1'b1;
        end
      end
      clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (clr_addr_r == IDX_W'(RESULT_DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    info.busy      = busy_r;
    info.err       = static_err | ovf_r;
    info.clr_addr  = clr_addr_r;
    info.len       = len_r;
    info.dim_count = dim_count_r;
    for (int j = 0; j < MAX_DIMS; j++) begin
      info.extent[j] = extent_r[j];
      info.stride[j] = stride_r[j];
    end
  end

endmodule

FILE: rtl/core/ams_front.sv
// ams_front: accepts input words, tracks the element coordinate and drain pointer,
// and queues each word with its accumulator address; depends on: ams_pkg, ams_ifs
`timescale 1ns / 1ps

module ams_front import ams_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ams_in_if.sink      in_ch,
  input  cfg_info_t   cfg,
  input  logic        q_full,
  output logic        push,
  output q_item_t     push_item
);

  logic [COORD_W-1:0]  coord_r   [MAX_DIMS];
  logic [IDX_W-1:0]    contrib_r [MAX_DIMS];
  logic [IDX_W-1:0]    dptr_r;

  logic [COORD_W-1:0]  coord_nxt   [MAX_DIMS];
  logic [IDX_W-1:0]    contrib_nxt [MAX_DIMS];
  logic [IDX_W-1:0]    dptr_nxt;

  logic                accept;
  logic                is_drain;
  logic                dptr_last;
  logic [IDX_W-1:0]    elem_idx;

  assign in_ch.ready = !cfg.busy && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_drain    = (in_ch.kind == KIND_DRAIN);
  assign dptr_last   = (LEN_W'(dptr_r) + LEN_W'(1) == cfg.len);
  assign dptr_nxt    = dptr_last ? '0 : dptr_r + IDX_W'(1);

  // address is the sum of per-margin offsets; non-kept margins have stride zero
  always_comb begin
    elem_idx = '0;
    for (int j = 0; j < MAX_DIMS; j++) begin
      elem_idx = elem_idx + contrib_r[j];
    end
  end

  // column-major step with carry into the slower margins
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int j = 0; j < MAX_DIMS; j++) begin
      coord_nxt[j]   = coord_r[j];
      contrib_nxt[j] = contrib_r[j];
      if (carry && DIM_W'(j) < cfg.dim_count) begin
        if (EXT_W'(coord_r[j]) + EXT_W'(1) == cfg.extent[j]) begin
          coord_nxt[j]   = '0;
          contrib_nxt[j] = '0;
        end else begin
          coord_nxt[j]   = coord_r[j] + COORD_W'(1);
          contrib_nxt[j] = contrib_r[j] + cfg.stride[j];
          carry          = 1'b0;
        end
      end else begin
        carry = 1'b0;
      end
    end
  end

  assign push = accept && (is_drain || !cfg.err);

  always_comb begin
    push_item.drain = is_drain;
    push_item.err   = cfg.err;
    push_item.last  = dptr_last;
    push_item.addr  = is_drain ? dptr_r : elem_idx;
    push_item.value = in_ch.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.busy) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        coord_r[j]   <= '0;
        contrib_r[j] <= '0;
      end
      dptr_r <= '0;
    end else if (accept && !cfg.err) begin
      if (is_drain) begin
        dptr_r <= dptr_nxt;
      end else begin
        for (int j = 0; j < MAX_DIMS; j++) begin
          coord_r[j]   <= coord_nxt[j];
          contrib_r[j] <= contrib_nxt[j];
        end
      end
    end
  end

endmodule

FILE: rtl/core/ams_fifo.sv
// ams_fifo: short queue of classified words between front and back
// depends on: ams_pkg, array_margin_sum_defines.svh
`timescale 1ns / 1ps
`include "array_margin_sum_defines.svh"

module ams_fifo import ams_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_item_t  push_item,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output q_item_t  head
);

  q_item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `AMS_ASSERT(a_count_bound, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
  `AMS_ASSERT_IMP(a_no_push_full, push, !full, "word pushed into a full queue")
  `AMS_ASSERT_IMP(a_no_pop_empty, pop, !empty, "word popped from an empty queue")

endmodule

FILE: rtl/core/ams_back.sv
// ams_back: read-modify-write of the sum memory with forwarding, and result register
// depends on: ams_pkg, ams_ifs, array_margin_sum_defines.svh
`timescale 1ns / 1ps
`include "array_margin_sum_defines.svh"

module ams_back import ams_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_info_t   cfg,
  input  logic        q_empty,
  input  q_item_t     head,
  output logic        pop,
  ams_out_if.source   out_ch
);

  acc_word_t           acc_mem [RESULT_DEPTH];
  acc_word_t           rd_word_r;

  logic                s1_valid_r;
  q_item_t             s1_item_r;

  logic                wb_valid_r;
  logic [IDX_W-1:0]    wb_addr_r;
  acc_word_t           wb_word_r;

  logic                out_valid_r;
  logic [SUM_W-1:0]    out_sum_r;
  logic [IDX_W-1:0]    out_index_r;
  logic                out_last_r;
  logic                out_sat_r;
  logic                out_err_r;

  logic                out_free;
  logic                s1_adv;
  logic                s1_write;
  acc_word_t           cur_word;
  acc_word_t           elem_word;
  acc_word_t           wr_word;
  logic [SUM_W:0]      add_wide;
  logic                add_ovf;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && (!s1_item_r.drain || out_free);
  assign pop      = !q_empty && (!s1_valid_r || s1_adv);
  assign s1_write = s1_adv && !s1_item_r.err && !cfg.busy;

  // the most recently written word is not yet in the registered read data
  assign cur_word = (wb_valid_r && wb_addr_r == s1_item_r.addr) ? wb_word_r : rd_word_r;

  assign add_wide = {cur_word.sum[SUM_W-1], cur_word.sum}
                  + {{(SUM_W+1-VALUE_W){s1_item_r.value[VALUE_W-1]}}, s1_item_r.value};
  assign add_ovf  = (add_wide[SUM_W] != add_wide[SUM_W-1]);

  always_comb begin
    elem_word.sat = cur_word.sat | add_ovf;
    if (add_ovf) begin
      elem_word.sum = add_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      elem_word.sum = add_wide[SUM_W-1:0];
    end
  end

  // a drain clears its entry
  assign wr_word = s1_item_r.drain ? '0 : elem_word;

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_word_r <= acc_mem[head.addr];
    end
    if (cfg.busy) begin
      acc_mem[cfg.clr_addr] <= '0;
    end else if (s1_write) begin
      acc_mem[s1_item_r.addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg.busy) begin
        wb_valid_r <= 1'b0;
      end else if (s1_write) begin
        wb_valid_r <= 1'b1;
      end
      if (s1_adv && s1_item_r.drain) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= head;
    end
    if (s1_write) begin
      wb_addr_r <= s1_item_r.addr;
      wb_word_r <= wr_word;
    end
    if (s1_adv && s1_item_r.drain) begin
      if (s1_item_r.err) begin
        out_sum_r   <= '0;
        out_index_r <= '0;
        out_last_r  <= 1'b1;
        out_sat_r   <= 1'b0;
        out_err_r   <= 1'b1;
      end else begin
        out_sum_r   <= cur_word.sum;
        out_index_r <= s1_item_r.addr;
        out_last_r  <= s1_item_r.last;
        out_sat_r   <= cur_word.sat;
        out_err_r   <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sum          = out_sum_r;
  assign out_ch.out_index    = out_index_r;
  assign out_ch.last         = out_last_r;
  assign out_ch.saturated    = out_sat_r;
  assign out_ch.config_error = out_err_r;

  `AMS_ASSERT_IMP(a_err_result_form, out_valid_r && out_err_r, out_last_r && out_index_r == '0 && out_sum_r == '0 && !out_sat_r, "bad-config result not in fixed form")
  `AMS_ASSERT_NXT(a_stall_holds_s1, s1_valid_r && s1_item_r.drain && !out_free, s1_valid_r && $stable(s1_item_r), "stalled drain lost its stage")
  `AMS_ASSERT_NXT(a_write_recorded, s1_write, wb_valid_r && wb_addr_r == $past(s1_item_r.addr), "write not held for forwarding")

endmodule

FILE: rtl/core/array_margin_sum.sv
// array_margin_sum: top level of the margin sum block
// depends on: ams_pkg, ams_ifs, ams_cfg, ams_front, ams_fifo, ams_back
`timescale 1ns / 1ps

// Usage
//   in_ch carries words: kind element adds value into the sum picked by the
//   kept coordinates of the current element; kind drain reads the next sum.
//   out_ch carries one result word per drain: sum, out_index, last, saturated
//   and config_error. Element words give no result.
//   cfg_we/cfg_idx/cfg_data write one register per edge; write only when idle.
// Throughput: one word per cycle unless out_ch stalls or a clearing pass runs;
//   elements and drains mix freely; the limit is the single read-modify-write
//   port of the 1024-entry sum memory, kept at full rate by forwarding the
//   last written word.
// A drain word passes the queue, back stage and result register to out_ch.
// Reset and configuration writes start a clearing pass over the whole sum
//   memory (one memory entry a cycle) during which in_ch.ready is low; the
//   coordinate counter and drain pointer return to zero.
// When the receiver stalls, the result register holds its word, the back
//   stage and the two-word queue fill, and then in_ch.ready drops.

module array_margin_sum import ams_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  ams_in_if.sink                 in_ch,
  ams_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_info_t  cfg_info;
  logic       push;
  q_item_t    push_item;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  q_item_t    q_head;

  ams_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .info     (cfg_info)
  );

  ams_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_info),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ams_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  ams_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_info),
    .q_empty (q_empty),
    .head    (q_head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking bench for array_margin_sum, with an in-bench margin sum predictor
// depends on: ams_pkg, ams_ifs and the array_margin_sum rtl
`timescale 1ns / 1ps

module tb_top import ams_pkg::*; ();

  localparam int QUIET_CYCLES = 8;
  localparam int STALL_LIMIT  = 8000;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 1000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_TOP    = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_BOTTOM = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam longint SUM_HI = SUM_MAX;
  localparam longint SUM_LO = SUM_MIN;

  typedef struct {
    logic                      kind;
    logic signed [VALUE_W-1:0] value;
  } feed_word_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        index;
    logic                    last;
    logic                    clipped;
    logic                    bad_layout;
  } sum_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ams_in_if  in_if ();
  ams_out_if out_if ();

  array_margin_sum u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  feed_word_t  pending_words[$];
  sum_word_t   expected_sums[$];
  int          mismatches;
  int          results_seen;
  int unsigned tx_gap_max;
  int unsigned rx_gap_max;
  int unsigned feed_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // predictor copy of the registers and the block state
  logic [DIM_W-1:0]   margin_count;
  logic [EXT_W-1:0]   margin_size [MAX_DIMS];
  logic [KEPT_W-1:0]  kept_total;
  logic [ORDER_W-1:0] kept_slots;
  int unsigned        elem_coord [MAX_DIMS];
  longint             sum_store [RESULT_DEPTH];
  bit                 clip_marks [RESULT_DEPTH];
  int unsigned        read_ptr;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned kept_axis(int unsigned slot);
    return kept_slots[2*slot +: 2];
  endfunction

  // number of sums in the result, zero for a bad layout
  function automatic int unsigned result_span();
    int unsigned span, m;
    int j, k;
    span = 1;
    if (margin_count < 2 || margin_count > MAX_DIMS) return 0;
    for (j = 0; j < margin_count; j++)
      if (margin_size[j] == 0 || margin_size[j] > MAX_EXTENT) return 0;
    if (kept_total < 1 || kept_total >= margin_count) return 0;
    for (j = 0; j < kept_total; j++) begin
      m = kept_axis(j);
      if (m >= margin_count) return 0;
      for (k = 0; k < j; k++)
        if (kept_axis(k) == m) return 0;
      span *= margin_size[m];
      if (span > RESULT_DEPTH) return 0;
    end
    return span;
  endfunction

  function automatic void clear_sums();
    int j;
    for (j = 0; j < MAX_DIMS; j++) elem_coord[j] = 0;
    for (j = 0; j < RESULT_DEPTH; j++) begin
      sum_store[j]  = 0;
      clip_marks[j] = 1'b0;
    end
    read_ptr = 0;
  endfunction

  function automatic void predict_word(logic kind, logic signed [VALUE_W-1:0] value);
    int unsigned span, slot, stride, m;
    longint      v, s;
    sum_word_t   want;
    int          j;
    span = result_span();
    if (kind == KIND_ELEM) begin
      if (span == 0) return;
      v = longint'(value);
      slot = 0;
      stride = 1;
      for (j = 0; j < kept_total; j++) begin
        m = kept_axis(j);
        slot += elem_coord[m] * stride;
        stride *= margin_size[m];
      end
      if (slot >= RESULT_DEPTH) slot = 0;
      s = sum_store[slot];
      if (v > 0 && s > SUM_HI - v) begin
        s = SUM_HI;
        clip_marks[slot] = 1'b1;
      end else if (v < 0 && s < SUM_LO - v) begin
        s = SUM_LO;
        clip_marks[slot] = 1'b1;
      end else begin
        s += v;
      end
      sum_store[slot] = s;
      // column-major step, margin 0 fastest
      for (j = 0; j < margin_count; j++) begin
        elem_coord[j]++;
        if (elem_coord[j] < margin_size[j]) break;
        elem_coord[j] = 0;
      end
      return;
    end
    if (span == 0) begin
      want = '{sum: '0, index: '0, last: 1'b1, clipped: 1'b0, bad_layout: 1'b1};
      expected_sums.push_back(want);
      return;
    end
    if (read_ptr >= span) read_ptr = 0;
    want.sum        = sum_store[read_ptr];
    want.index      = read_ptr[IDX_W-1:0];
    want.last       = (read_ptr + 1 == span);
    want.clipped    = clip_marks[read_ptr];
    want.bad_layout = 1'b0;
    expected_sums.push_back(want);
    sum_store[read_ptr]  = 0;
    clip_marks[read_ptr] = 1'b0;
    read_ptr++;
    if (read_ptr >= span) read_ptr = 0;
  endfunction

  // stimulus side
  always @(posedge clk) begin : feed_words
    feed_word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      feed_gap    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (feed_gap != 0) begin
        in_if.valid <= 1'b0;
        feed_gap    <= feed_gap - 1;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_if.valid <= 1'b1;
        in_if.kind  <= w.kind;
        in_if.value <= w.value;
        feed_gap    <= $urandom_range(0, tx_gap_max);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : track_words
    if (rst_n && in_if.valid && in_if.ready) predict_word(in_if.kind, in_if.value);
  end

  always @(posedge clk) begin : pace_results
    int unsigned next_stall;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        // long hold-off so the queue backs up and in_ch.ready drops
        if (results_seen == HOLD_AFTER || $urandom_range(0, 299) == 0)
          next_stall = HOLD_CYCLES;
        else
          next_stall = $urandom_range(0, rx_gap_max);
      end else if (stall_left != 0) begin
        next_stall = stall_left - 1;
      end else begin
        next_stall = 0;
      end
      stall_left   <= next_stall;
      out_if.ready <= (next_stall == 0);
    end
  end

  always @(posedge clk) begin : check_results
    sum_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_sums.size() == 0) begin
        $error("result word with nothing expected: index %0d sum %0d",
               out_if.out_index, out_if.sum);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (out_if.sum !== want.sum) begin
          $error("sum: expected %0d, got %0d", want.sum, out_if.sum);
          mismatches++;
        end
        if (out_if.out_index !== want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, out_if.out_index);
          mismatches++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_if.last);
          mismatches++;
        end
        if (out_if.saturated !== want.clipped) begin
          $error("saturated: expected %0b, got %0b", want.clipped, out_if.saturated);
          mismatches++;
        end
        if (out_if.config_error !== want.bad_layout) begin
          $error("config_error: expected %0b, got %0b", want.bad_layout,
                 out_if.config_error);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("array_margin_sum regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_TOP;
      1:       return VALUE_BOTTOM;
      2:       return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_word(logic kind, logic signed [VALUE_W-1:0] value);
    feed_word_t w;
    w.kind  = kind;
    w.value = value;
    pending_words.push_back(w);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_DIM_COUNT:  margin_count   = data[DIM_W-1:0];
      REG_EXTENT_0:   margin_size[0] = data[EXT_W-1:0];
      REG_EXTENT_1:   margin_size[1] = data[EXT_W-1:0];
      REG_EXTENT_2:   margin_size[2] = data[EXT_W-1:0];
      REG_EXTENT_3:   margin_size[3] = data[EXT_W-1:0];
      REG_KEPT_COUNT: kept_total     = data[KEPT_W-1:0];
      REG_KEPT_ORDER: kept_slots     = data[ORDER_W-1:0];
      default: ;
    endcase
    if (idx != REG_SPARE) clear_sums();
  endtask

  // narrow registers get junk in the unused upper data bits
  task automatic program_layout(input logic [DIM_W-1:0] dims,
                                input logic [MAX_DIMS-1:0][EXT_W-1:0] ext,
                                input logic [KEPT_W-1:0] kept,
                                input logic [ORDER_W-1:0] order);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[DIM_W-1:0] = dims;
    write_reg(REG_DIM_COUNT, data);
    write_reg(REG_EXTENT_0, ext[0]);
    write_reg(REG_EXTENT_1, ext[1]);
    write_reg(REG_EXTENT_2, ext[2]);
    write_reg(REG_EXTENT_3, ext[3]);
    data = CFG_DATA_W'($urandom);
    data[KEPT_W-1:0] = kept;
    write_reg(REG_KEPT_COUNT, data);
    data = CFG_DATA_W'($urandom);
    data[ORDER_W-1:0] = order;
    write_reg(REG_KEPT_ORDER, data);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_layout(input int shape,
                             output logic [DIM_W-1:0] dims,
                             output logic [MAX_DIMS-1:0][EXT_W-1:0] ext,
                             output logic [KEPT_W-1:0] kept,
                             output logic [ORDER_W-1:0] order);
    int perm [MAX_DIMS];
    int j, k, t;
    for (j = 0; j < MAX_DIMS; j++) ext[j] = EXT_W'($urandom_range(0, 511));
    order = ORDER_W'($urandom);
    case (shape)
      0: begin
        // widest single kept margin
        dims = DIM_W'(2);
        kept = KEPT_W'(1);
        ext[0] = EXT_W'(MAX_EXTENT);
        ext[1] = EXT_W'($urandom_range(1, 3));
        order[1:0] = SLOT_W'(0);
      end
      1: begin
        // kept extents fill the whole sum memory, second margin fastest
        dims = DIM_W'(3);
        kept = KEPT_W'(2);
        ext[0] = EXT_W'(MAX_EXTENT);
        ext[1] = EXT_W'(4);
        ext[2] = EXT_W'($urandom_range(1, 2));
        order[3:0] = 4'b00_01;
      end
      2: begin
        dims = DIM_W'(4);
        kept = KEPT_W'(1);
        for (j = 0; j < MAX_DIMS; j++) ext[j] = EXT_W'($urandom_range(1, 3));
        order = '1;
      end
      3: begin
        dims = DIM_W'(4);
        kept = KEPT_W'(3);
        for (j = 0; j < MAX_DIMS; j++) ext[j] = EXT_W'($urandom_range(1, 3));
        order = '0;
      end
      default: begin
        dims = DIM_W'($urandom_range(2, MAX_DIMS));
        kept = KEPT_W'($urandom_range(1, dims - 1));
        for (j = 0; j < MAX_DIMS; j++) perm[j] = j;
        for (j = dims - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          t = perm[j];
          perm[j] = perm[k];
          perm[k] = t;
        end
        for (j = 0; j < dims; j++) ext[j] = EXT_W'($urandom_range(1, 4));
        for (j = 0; j < kept; j++) order[2*j +: 2] = SLOT_W'(perm[j]);
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 5))
            0: dims = DIM_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 1)
                                                        : $urandom_range(MAX_DIMS + 1, 7));
            1: ext[SLOT_W'($urandom_range(0, dims - 1))] =
                 EXT_W'(($urandom_range(0, 1) != 0) ? 0
                                                     : $urandom_range(MAX_EXTENT + 1, 511));
            2: kept = KEPT_W'((dims == MAX_DIMS || $urandom_range(0, 1) != 0)
                              ? 0 : $urandom_range(dims, 3));
            3: begin
              if (dims < MAX_DIMS)
                order[2*$urandom_range(0, kept - 1) +: 2] = SLOT_W'($urandom_range(dims, 3));
              else
                ext[0] = '0;
            end
            4: begin
              if (kept >= 2) order[3:2] = order[1:0];
              else ext[0] = '0;
            end
            default: begin
              if (kept >= 2) begin
                ext[order[1:0]] = EXT_W'(MAX_EXTENT);
                ext[order[3:2]] = EXT_W'($urandom_range(5, MAX_EXTENT));
              end else begin
                ext[0] = EXT_W'(MAX_EXTENT + 1);
              end
            end
          endcase
        end
      end
    endcase
  endtask

  // mostly element bursts then up to 128 drains, whole passes for small arrays; the rest is a loose mix
  task automatic queue_phase(input int budget, output int counted);
    longint      whole;
    int unsigned span;
    int          j, burst, reads;
    logic        kind;
    span = result_span();
    whole = 1;
    for (j = 0; j < margin_count && j < MAX_DIMS; j++) whole *= margin_size[j];
    counted = 0;
    while (counted < budget) begin
      if (span != 0 && $urandom_range(0, 9) < 6) begin
        burst = (whole <= 96) ? int'(whole) * $urandom_range(1, 2) : $urandom_range(1, 96);
        reads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : span;
        if (reads > 128) reads = 128;
        repeat (burst) queue_word(KIND_ELEM, pick_value());
        repeat (reads) queue_word(KIND_DRAIN, pick_value());
        counted += burst + reads;
      end else begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          kind = ($urandom_range(0, 1) != 0) ? KIND_DRAIN : KIND_ELEM;
          queue_word(kind, pick_value());
          // elements under a bad layout are dropped by the block
          if (span != 0 || kind == KIND_DRAIN) counted++;
        end
      end
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_if.valid || expected_sums.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0]                  dims;
    logic [MAX_DIMS-1:0][EXT_W-1:0]    ext;
    logic [KEPT_W-1:0]                 kept;
    logic [ORDER_W-1:0]                order;
    int                                phase, random_words, counted, budget;
    int                                j;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_DIM_COUNT;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.kind   = KIND_ELEM;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    tx_gap_max   = 0;
    rx_gap_max   = 0;
    margin_count = DIM_W'(2);
    kept_total   = KEPT_W'(1);
    kept_slots   = '0;
    for (j = 0; j < MAX_DIMS; j++) margin_size[j] = EXT_W'(1);
    clear_sums();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: one sum, fed with the value extremes
    queue_word(KIND_ELEM, VALUE_TOP);
    queue_word(KIND_ELEM, VALUE_BOTTOM);
    queue_word(KIND_ELEM, -1);
    queue_word(KIND_ELEM, 1);
    queue_word(KIND_DRAIN, VALUE_TOP);
    queue_word(KIND_DRAIN, 0);
    queue_word(KIND_ELEM, VALUE_TOP);
    queue_word(KIND_ELEM, VALUE_TOP);
    queue_word(KIND_DRAIN, VALUE_BOTTOM);
    wait_quiet();

    // margin count out of range: elements dropped, drains flag the error
    ext = {EXT_W'(2), EXT_W'(2), EXT_W'(2), EXT_W'(2)};
    program_layout(3'd7, ext, 2'd1, 8'h00);
    queue_word(KIND_ELEM, VALUE_TOP);
    queue_word(KIND_DRAIN, 0);
    wait_quiet();

    // four margins, three kept out of order; drains run past the last sum
    ext = {EXT_W'(2), EXT_W'(1), EXT_W'(1), EXT_W'(2)};
    program_layout(3'd4, ext, 2'd3, 8'b10_01_00_11);
    for (j = 0; j < 4; j++) queue_word(KIND_ELEM, pick_value());
    repeat (5) queue_word(KIND_DRAIN, 0);
    wait_quiet();

    phase = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      pick_layout(phase, dims, ext, kept, order);
      program_layout(dims, ext, kept, order);
      case ($urandom_range(0, 3))
        0: begin
          tx_gap_max = 0;
          rx_gap_max = 0;
        end
        default: begin
          tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
          rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
        end
      endcase
      budget = (result_span() != 0) ? $urandom_range(40, 150) : $urandom_range(8, 24);
      queue_phase(budget, counted);
      random_words += counted;
      wait_quiet();
      phase++;
    end

    if (mismatches == 0) begin
      $display("array_margin_sum regression: pass");
    end else begin
      $display("array_margin_sum regression: fail");
    end
    $finish;
  end

endmodule
